/* src/sha256_byte_stream_hasher_assert.svh */
// Assertion macros shared by the checker of the byte-stream hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
// Property checked on every rising clock edge outside reset.
`define SHA_ASSERT_CLK(lbl, clk_s, rst_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
		else $error("sha256 hasher assertion failed");
// Property checked on every edge, during reset too.
`define SHA_ASSERT_ALWAYS(lbl, clk_s, prop) \
	lbl: assert property (@(posedge clk_s) prop) \
		else $error("sha256 hasher assertion failed");
`endif

/* src/sha_pkg.sv */
// Package with the shared types, constants and round table of the SHA-256 hasher.
`timescale 1ns / 1ps
package sha_pkg;
	localparam logic [1:0] BSEL_DATA = 2'd0;
	localparam logic [1:0] BSEL_MARK = 2'd1;
	localparam logic [1:0] BSEL_ZERO = 2'd2;
	localparam logic [1:0] BSEL_LEN  = 2'd3;

	localparam logic [7:0] PAD_MARK = 8'h80;

	typedef logic [31:0] word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic [1:0] bsel;
		logic       count;
		logic       start;
		logic       round;
		logic [5:0] rnd;
		logic       add;
		logic [2:0] idx;
		logic       restart;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [5:0] fill;
	} stat_t;

	function automatic word_t init_hash(input logic [2:0] i);
		word_t r;
		unique case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic word_t round_k(input logic [5:0] i);
		word_t r;
		unique case (i)
			6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
			6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
			6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
			6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
			6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
			6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
			6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
			6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
			6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
			6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
			6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
			6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction
endpackage

/* src/sha_datapath.sv */
// Datapath of the SHA-256 hasher: block buffer, schedule, rounds, chain and length.
`timescale 1ns / 1ps
module sha_datapath (
	input  logic          clk,
	input  logic          arst_n,
	input  sha_pkg::cmd_t cmd,
	input  logic [7:0]    data_byte,
	output sha_pkg::stat_t stat,
	output logic [31:0]   digest_word
);
	import sha_pkg::*;

	logic [511:0] blk_q;
	word_t        chain_q [8];
	word_t        v_q [8];
	logic [63:0]  bit_count_q;
	logic [5:0]   fill_q;
	logic [7:0]   byte_in;
	logic [7:0]   len_byte;
	word_t        w0, w1, w9, w14, w_new;
	word_t        sig0, sig1, t1, t2, ch, maj, s0, s1;

	// Length bytes go out most significant first.
	assign len_byte = 8'(bit_count_q >> (6'd56 - {fill_q[2:0], 3'b000}));

	// Byte source for the buffer.
	always_comb begin
		unique case (cmd.bsel)
			BSEL_DATA: byte_in = data_byte;
			BSEL_MARK: byte_in = PAD_MARK;
			BSEL_ZERO: byte_in = 8'h00;
			default:   byte_in = len_byte;
		endcase
	end

	// Message schedule taps and next word.
	assign w0  = blk_q[511:480];
	assign w1  = blk_q[479:448];
	assign w9  = blk_q[223:192];
	assign w14 = blk_q[63:32];
	assign sig0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
	assign sig1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
	assign w_new = sig1 + w9 + sig0 + w0;

	// Round function.
	assign s1  = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
		^ {v_q[4][24:0], v_q[4][31:25]};
	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign t1  = v_q[7] + s1 + ch + round_k(cmd.rnd) + w0;
	assign s0  = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
		^ {v_q[0][21:0], v_q[0][31:22]};
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t2  = s0 + maj;

	// Buffer doubles as the schedule window during rounds.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			blk_q <= {blk_q[503:0], byte_in};
		end else if (cmd.round) begin
			blk_q <= {blk_q[479:0], w_new};
		end
	end

	// Working variables.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= chain_q[i];
		end else if (cmd.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// Chain value, length and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= init_hash(3'(i));
			bit_count_q <= '0;
			fill_q <= '0;
		end else begin
			if (cmd.restart) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= init_hash(3'(i));
				bit_count_q <= '0;
			end else if (cmd.add) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
			end else if (cmd.count) begin
				bit_count_q <= bit_count_q + 64'd8;
			end
			if (cmd.load) fill_q <= fill_q + 6'd1;
		end
	end

	assign stat.fill = fill_q;
	assign digest_word = chain_q[cmd.idx];
endmodule

/* src/sha_ctrl.sv */
// Controller state machine of the SHA-256 hasher.
`timescale 1ns / 1ps
module sha_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           kind,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     word_index,
	output logic           last_word,
	input  sha_pkg::stat_t stat,
	output sha_pkg::cmd_t  cmd
);
	import sha_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_COMP = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       pad_q, pad_d, first_q, first_d, lenok_q, lenok_d;
	logic [5:0] rnd_q, rnd_d;
	logic [2:0] idx_q, idx_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		pad_d = pad_q;
		first_d = first_q;
		lenok_d = lenok_q;
		rnd_d = rnd_q;
		idx_d = idx_q;
		cmd = '0;
		cmd.rnd = rnd_q;
		cmd.idx = idx_q;
		cmd.bsel = BSEL_DATA;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!kind) begin
						cmd.load = 1'b1;
						cmd.count = 1'b1;
						pad_d = 1'b0;
						if (stat.fill == 6'd63) begin
							cmd.start = 1'b1;
							rnd_d = '0;
							state_d = ST_COMP;
						end
					end else begin
						pad_d = 1'b1;
						first_d = 1'b1;
						lenok_d = (stat.fill < 6'd56);
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.load = 1'b1;
				priority if (first_q) begin
					cmd.bsel = BSEL_MARK;
				end else if (lenok_q && stat.fill >= 6'd56) begin
					cmd.bsel = BSEL_LEN;
				end else begin
					cmd.bsel = BSEL_ZERO;
				end
				first_d = 1'b0;
				if (stat.fill == 6'd63) begin
					cmd.start = 1'b1;
					rnd_d = '0;
					state_d = ST_COMP;
				end
			end
			ST_COMP: begin
				cmd.round = 1'b1;
				rnd_d = rnd_q + 6'd1;
				if (rnd_q == 6'd63) state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				priority if (!pad_q) begin
					state_d = ST_IDLE;
				end else if (lenok_q) begin
					idx_d = '0;
					state_d = ST_OUT;
				end else begin
					lenok_d = 1'b1;
					state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						cmd.restart = 1'b1;
						pad_d = 1'b0;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pad_q <= 1'b0;
			first_q <= 1'b0;
			lenok_q <= 1'b0;
			rnd_q <= '0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			pad_q <= pad_d;
			first_q <= first_d;
			lenok_q <= lenok_d;
			rnd_q <= rnd_d;
			idx_q <= idx_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign word_index = idx_q;
	assign last_word = (idx_q == 3'd7);
endmodule

/* src/sha256_byte_stream_hasher.sv */
// Top level of the SHA-256 byte-stream hasher.
// Input channel: in_valid/in_ready with kind and data_byte. A word with kind 0
// adds one message byte; a word with kind 1 ends the message.
// Output channel: out_valid/out_ready with digest_word, word_index, last_word;
// a finish yields eight words, index 0 first, last_word set on index 7.
// The 64th message byte of a block starts the compression, which holds
// in_ready low through 64 rounds on one shared round unit and the chain add.
// A finish writes the padding one byte a cycle, then compresses; when fewer
// than 9 bytes of room remain a second padded block follows. The digest
// words then stream out at one per cycle while out_ready is high.
// When the receiver stalls, the current word holds and no input is taken.
// After the eighth word the chain and length return to their initial values.
// Reset is asynchronous and active low: the chain takes the SHA-256 initial
// values, the length and fill clear, and the block is ready for a new message.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Controller.
	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.out_valid(out_valid), .out_ready(out_ready),
		.word_index(word_index), .last_word(last_word),
		.stat(stat), .cmd(cmd)
	);

	// Datapath.
	sha_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .data_byte(data_byte),
		.stat(stat), .digest_word(digest_word)
	);
endmodule

/* src/sha_checker.sv */
// Port checker of the SHA-256 hasher and its bind to the top level.
`timescale 1ns / 1ps
`include "sha256_byte_stream_hasher_assert.svh"
module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);
	// A stalled digest word holds.
	`SHA_ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
	// Words advance in order through the digest.
	`SHA_ASSERT_CLK(a_idx_step, clk, arst_n, out_valid && out_ready && !last_word |=> out_valid && word_index == $past(word_index) + 3'd1)
	// The last flag marks the eighth word only.
	`SHA_ASSERT_ALWAYS(a_last, clk, last_word == (word_index == 3'd7))
	// No word is taken in while a digest is pending.
	`SHA_ASSERT_CLK(a_excl, clk, arst_n, !(out_valid && in_ready))
endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .digest_word(digest_word),
	.word_index(word_index), .last_word(last_word)
);
